// File: sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants for the binary/BCD converter digit chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

	localparam int WORD_W  = 32;
	localparam int DIGIT_W = 4;

	// Selector codes
	localparam logic FUNC_BIN2BCD = 1'b0;
	localparam logic FUNC_BCD2BIN = 1'b1;

	// floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
	localparam logic [WORD_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int                RECIP_SHIFT = 35;

	localparam logic [DIGIT_W-1:0] NIB_MAX = 4'h9;

	// Item as it travels down the chain.
	// acc : remaining binary value (bin->bcd) or running sum (bcd->bin)
	// word: BCD result being built (bin->bcd) or packed BCD source (bcd->bin)
	typedef struct packed {
		logic              func;
		logic [WORD_W-1:0] acc;
		logic [WORD_W-1:0] word;
		logic              ok;
	} cell_data_t;

endpackage

`default_nettype wire

// File: sv/bbc_if.sv
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channels for converter requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbc_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] value_in;

	modport source (output valid, output func, output value_in, input ready);
	modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface bbc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_out;
	logic        digits_ok;

	modport source (output valid, output value_out, output digits_ok, input ready);
	modport sink   (input valid, input value_out, input digits_ok, output ready);
endinterface

`default_nettype wire

// File: sv/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// One decimal digit of the chain: peels one digit off (bin->bcd) or folds
// one nibble in (bcd->bin), then registers the item for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_cell #(
	parameter int IDX  = 0,
	parameter int NDIG = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  bbc_pkg::cell_data_t     in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output bbc_pkg::cell_data_t     out_data
);

	// bin->bcd fills digits from the low end, bcd->bin reads from the top
	localparam int BIN_POS = IDX;
	localparam int BCD_POS = NDIG - 1 - IDX;

	logic                     valid_q;
	bbc_pkg::cell_data_t      data_q;
	bbc_pkg::cell_data_t      nxt;

	logic [2*bbc_pkg::WORD_W-1:0] prod;
	logic [bbc_pkg::WORD_W-1:0]   quot;
	logic [bbc_pkg::WORD_W-1:0]   rem;
	logic [bbc_pkg::DIGIT_W-1:0]  nib;

	always_comb begin
		prod = {{bbc_pkg::WORD_W{1'b0}}, in_data.acc}
			* {{bbc_pkg::WORD_W{1'b0}}, bbc_pkg::RECIP_10};
		quot = bbc_pkg::WORD_W'(prod >> bbc_pkg::RECIP_SHIFT);
		rem  = in_data.acc - ((quot << 3) + (quot << 1));
		nib  = in_data.word[BCD_POS*bbc_pkg::DIGIT_W +: bbc_pkg::DIGIT_W];

		nxt = in_data;
		if (in_data.func == bbc_pkg::FUNC_BIN2BCD) begin
			nxt.acc = quot;
			nxt.word[BIN_POS*bbc_pkg::DIGIT_W +: bbc_pkg::DIGIT_W] =
				rem[bbc_pkg::DIGIT_W-1:0];
		end else begin
			nxt.acc = (in_data.acc << 3) + (in_data.acc << 1)
				+ {{(bbc_pkg::WORD_W-bbc_pkg::DIGIT_W){1'b0}}, nib};
			nxt.ok  = in_data.ok & (nib <= bbc_pkg::NIB_MAX);
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: sv/bcd_binary_converter_top.sv
// ----------------------------------------------------------------------------
// bcd_binary_converter_top
// Binary <-> packed BCD converter built as a chain of digit cells.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while res.ready is high, and its result
// leaves the last cell of the chain (DIGIT_COUNT clamped to 1..8). The chain has one cell per decimal
// digit, each with a registered output stage and its own valid bit, so
// latency is set by the digit count. Each cell does a combinational
// divide-by-ten (reciprocal multiply) for func 0, a times-ten add for
// func 1. Ready flows back cell by cell, so empty slots in the chain keep
// taking items while a finished result waits on the output. func 0 returns
// value_in mod 10^N as packed BCD with digits_ok set when value_in < 10^N;
// func 1 weights each low nibble by its power of ten (even above nine) and
// sets digits_ok only when every used nibble is at most nine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_binary_converter_top #(
	parameter int DIGIT_COUNT = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	bbc_in_if.sink      cmd,
	bbc_out_if.source   res
);

	localparam int NDIG = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 8) ? 8 : DIGIT_COUNT);

	logic                chain_valid [0:NDIG];
	logic                chain_ready [0:NDIG];
	bbc_pkg::cell_data_t chain_data  [0:NDIG];
	bbc_pkg::cell_data_t last;

	always_comb begin
		chain_data[0].func = cmd.func;
		chain_data[0].ok   = 1'b1;
		if (cmd.func == bbc_pkg::FUNC_BIN2BCD) begin
			chain_data[0].acc  = cmd.value_in;
			chain_data[0].word = '0;
		end else begin
			chain_data[0].acc  = '0;
			chain_data[0].word = cmd.value_in;
		end
	end

	assign chain_valid[0] = cmd.valid;
	assign cmd.ready      = chain_ready[0];

	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		bbc_cell #(
			.IDX  (i),
			.NDIG (NDIG)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	assign last             = chain_data[NDIG];
	assign chain_ready[NDIG] = res.ready;
	assign res.valid        = chain_valid[NDIG];

	// bin->bcd: anything left after N digits means the input was too large
	always_comb begin
		if (last.func == bbc_pkg::FUNC_BIN2BCD) begin
			res.value_out = last.word;
			res.digits_ok = (last.acc == '0);
		end else begin
			res.value_out = last.acc;
			res.digits_ok = last.ok;
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_bcd_binary_converter_top.sv
// ----------------------------------------------------------------------------
// tb_bcd_binary_converter_top
// Self-checking bench for the binary <-> packed BCD converter.
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus block fills: first boundary
// words for both directions, then random binary values and BCD words in four
// flow-control phases. The monitor predicts each accepted request and checks
// every result, in order, field by field. The receiver holds off for a long
// stretch once, so the chain fills. The sender pauses once mid-phase until the chain drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bcd_binary_converter_top;

	timeunit 1ns;
	timeprecision 1ps;

	import bbc_pkg::*;

	localparam int DIGIT_COUNT = 8;
	localparam int NUM_DIGITS  = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 8) ? 8 : DIGIT_COUNT);
	localparam int RANDOM_PER_PHASE = 432;
	localparam int RX_HOLD_CYCLES   = 250;

	typedef struct packed {
		logic              func;
		logic [WORD_W-1:0] value;
	} conv_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              ok;
	} conv_result_t;

	logic clk;
	logic arst_n;

	bbc_in_if  cmd ();
	bbc_out_if res ();

	bcd_binary_converter_top #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.res   (res)
	);

	conv_req_t    pending_words[$];
	conv_result_t awaited_results[$];
	conv_req_t    next_word;
	conv_result_t want;
	logic         cmd_taken;
	logic         tx_hold;
	int           rx_hold_left;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           err_count;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Expected conversion of one request
	function automatic conv_result_t converted_word(conv_req_t req);
		conv_result_t      r;
		logic [WORD_W-1:0] rest;
		logic [WORD_W-1:0] weight;
		logic [DIGIT_W-1:0] nib;
		r.value = '0;
		r.ok    = 1'b1;
		if (req.func == FUNC_BIN2BCD) begin
			rest = req.value;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				r.value[i*DIGIT_W +: DIGIT_W] = DIGIT_W'(rest % 10);
				rest = rest / 10;
			end
			r.ok = (rest == '0);
		end else begin
			weight = 1;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				nib = req.value[i*DIGIT_W +: DIGIT_W];
				if (nib > NIB_MAX)
					r.ok = 1'b0;
				r.value = r.value + WORD_W'(nib) * weight;
				weight  = weight * 10;
			end
		end
		return r;
	endfunction

	function automatic void queue_word(logic func, logic [WORD_W-1:0] value);
		conv_req_t req;
		req.func  = func;
		req.value = value;
		pending_words.push_back(req);
	endfunction

	function automatic logic [WORD_W-1:0] random_binary();
		logic [WORD_W-1:0] v;
		int                k;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(99999990, 100000010);
			2: v = $urandom_range(0, 999);
			3: begin
				k = $urandom_range(1, 9);
				v = 1;
				for (int i = 0; i < k; i++)
					v = v * 10;
				v = v - 2 + $urandom_range(0, 3);
			end
			default: v = $urandom_range(0, 99999999);
		endcase
		return v;
	endfunction

	// Mostly legal digit strings, some with a bad nibble, some raw words
	function automatic logic [WORD_W-1:0] random_bcd();
		logic [WORD_W-1:0] v;
		int                pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return $urandom;
		v = '0;
		for (int i = 0; i < WORD_W / DIGIT_W; i++)
			v[i*DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
		if (pick <= 2)
			v[$urandom_range(0, WORD_W / DIGIT_W - 1)*DIGIT_W +: DIGIT_W] =
				DIGIT_W'($urandom_range(10, 15));
		return v;
	endfunction

	// Driver: offer a new item once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else if (!cmd.valid || cmd_taken) begin
			if (!tx_hold && pending_words.size() != 0 &&
			    $urandom_range(0, 99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				cmd.valid    <= 1'b1;
				cmd.func     <= next_word.func;
				cmd.value_in <= next_word.value;
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else
			res.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(negedge clk) begin
		if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;
	end

	// Monitor: predict on input handshake, check on output handshake
	always @(posedge clk) begin
		cmd_taken <= cmd.valid && cmd.ready;
		if (arst_n && cmd.valid && cmd.ready)
			awaited_results.push_back(converted_word('{func: cmd.func, value: cmd.value_in}));
		if (arst_n && res.valid && res.ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: value_out %h digits_ok %b",
					res.value_out, res.digits_ok);
				err_count++;
			end else begin
				want = awaited_results.pop_front();
				if (res.value_out !== want.value) begin
					$error("value_out mismatch: expected %h, got %h", want.value, res.value_out);
					err_count++;
				end
				if (res.digits_ok !== want.ok) begin
					$error("digits_ok mismatch: expected %b, got %b", want.ok, res.digits_ok);
					err_count++;
				end
			end
		end
	end

	initial begin
		cmd.valid      = 1'b0;
		cmd.func       = FUNC_BIN2BCD;
		cmd.value_in   = '0;
		res.ready      = 1'b0;
		cmd_taken      = 1'b0;
		tx_hold        = 1'b0;
		rx_hold_left   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		err_count      = 0;
		arst_n         = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// boundaries: zero and small values, largest in-range value, first overflow, all ones, top bit
		queue_word(FUNC_BIN2BCD, 32'd0);
		queue_word(FUNC_BIN2BCD, 32'd1);
		queue_word(FUNC_BIN2BCD, 32'd9);
		queue_word(FUNC_BIN2BCD, 32'd10);
		queue_word(FUNC_BIN2BCD, 32'd12345678);
		queue_word(FUNC_BIN2BCD, 32'd99999999);
		queue_word(FUNC_BIN2BCD, 32'd100000000);
		queue_word(FUNC_BIN2BCD, 32'd100000001);
		queue_word(FUNC_BIN2BCD, 32'hFFFF_FFFF);
		queue_word(FUNC_BIN2BCD, 32'h8000_0000);
		// nibbles above nine still weigh in; all-F is the largest sum
		queue_word(FUNC_BCD2BIN, 32'h0000_0000);
		queue_word(FUNC_BCD2BIN, 32'h0000_0001);
		queue_word(FUNC_BCD2BIN, 32'h1234_5678);
		queue_word(FUNC_BCD2BIN, 32'h9999_9999);
		queue_word(FUNC_BCD2BIN, 32'hFFFF_FFFF);
		queue_word(FUNC_BCD2BIN, 32'h0000_000A);
		queue_word(FUNC_BCD2BIN, 32'hA000_0000);
		queue_word(FUNC_BCD2BIN, 32'h9999_999A);
		queue_word(FUNC_BCD2BIN, 32'h1000_0000);
		queue_word(FUNC_BCD2BIN, 32'h0F0F_0F0F);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(0, 1) == 0)
					queue_word(FUNC_BIN2BCD, random_binary());
				else
					queue_word(FUNC_BCD2BIN, random_bcd());
			end
			// long output stall while requests keep coming: chain fills up
			if (phase == 0)
				rx_hold_left = RX_HOLD_CYCLES;
			// sender pauses mid-phase until the chain is empty
			if (phase == 3) begin
				while (pending_words.size() > RANDOM_PER_PHASE / 2)
					@(posedge clk);
				tx_hold = 1'b1;
				while (cmd.valid || awaited_results.size() != 0)
					@(posedge clk);
				tx_hold = 1'b0;
			end
			while (pending_words.size() != 0 || cmd.valid || awaited_results.size() != 0)
				@(posedge clk);
		end

		repeat (4 * NUM_DIGITS + 8) @(posedge clk);
		if (err_count == 0 && awaited_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
sv/bbc_pkg.sv
sv/bbc_if.sv
sv/bbc_cell.sv
sv/bcd_binary_converter_top.sv
tb/tb_bcd_binary_converter_top.sv
